// ----- sv/wdfa_pkg.sv -----
`timescale 1ns / 1ps

package wdfa_pkg;

    // default sizes of the automaton
    localparam int STATES_DEF  = 256;
    localparam int SYMBOLS_DEF = 64;
    localparam int DIMS_DEF    = 4;

    // decoded operation queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // field widths
    localparam int CMD_W   = 3;
    localparam int SYM_W   = 6;
    localparam int STATE_W = 8;
    localparam int DIM_W   = 2;
    localparam int CNT_W   = 16;
    localparam int FREQ_W  = 32;
    localparam int ACC_W   = 32;
    localparam int TOT_W   = 64;

    // command codes on the input channel
    typedef enum logic [CMD_W-1:0] {
        CMD_SYMBOL     = 3'd0,
        CMD_WORD_END   = 3'd1,
        CMD_STREAM_END = 3'd2,
        CMD_WR_TRANS   = 3'd3,
        CMD_WR_FINAL   = 3'd4
    } cmd_t;

    // classified operation kinds
    typedef enum logic [2:0] {
        OP_STEP,
        OP_WORD,
        OP_END,
        OP_WR_TRANS,
        OP_WR_FINAL
    } op_kind_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic [SYM_W-1:0]           symbol;
        logic [STATE_W-1:0]         state_index;
        logic [STATE_W-1:0]         next_state;
        logic [DIM_W-1:0]           dim_index;
        logic signed [CNT_W-1:0]    count_value;
        logic signed [FREQ_W-1:0]   frequency;
    } op_t;

endpackage

// ----- sv/wdfa_ram.sv -----
`timescale 1ns / 1ps

module wdfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/wdfa_front.sv -----
`timescale 1ns / 1ps

module wdfa_front #(
    parameter int STATES  = wdfa_pkg::STATES_DEF,
    parameter int SYMBOLS = wdfa_pkg::SYMBOLS_DEF,
    parameter int DIMS    = wdfa_pkg::DIMS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wdfa_pkg::CMD_W-1:0]          s_cmd,
    input  logic [wdfa_pkg::SYM_W-1:0]          s_symbol,
    input  logic [wdfa_pkg::STATE_W-1:0]        s_state_index,
    input  logic [wdfa_pkg::STATE_W-1:0]        s_next_state,
    input  logic [wdfa_pkg::DIM_W-1:0]          s_dim_index,
    input  logic signed [wdfa_pkg::CNT_W-1:0]   s_count_value,
    input  logic signed [wdfa_pkg::FREQ_W-1:0]  s_frequency,
    output logic                                q_valid,
    output wdfa_pkg::op_t                       q_op,
    input  logic                                q_ready
);

    logic          f_valid_reg, f_valid_next;
    wdfa_pkg::op_t f_op_reg, f_op_next;
    wdfa_pkg::op_t dec_op;
    logic          keep;
    logic          sym_ok, row_ok, dim_ok;
    logic          accept;

    // range checks against the table sizes
    always_comb begin
        sym_ok = 32'(s_symbol) < 32'(SYMBOLS);
        row_ok = 32'(s_state_index) < 32'(STATES);
        dim_ok = 32'(s_dim_index) < 32'(DIMS);
    end

    // classify the command, drop items that do nothing
    always_comb begin
        dec_op.kind        = wdfa_pkg::OP_STEP;
        dec_op.symbol      = s_symbol;
        dec_op.state_index = s_state_index;
        dec_op.next_state  = s_next_state;
        dec_op.dim_index   = s_dim_index;
        dec_op.count_value = s_count_value;
        dec_op.frequency   = s_frequency;
        keep               = 1'b0;
        case (s_cmd)
            wdfa_pkg::CMD_SYMBOL: begin
                dec_op.kind = wdfa_pkg::OP_STEP;
                keep        = sym_ok;
            end
            wdfa_pkg::CMD_WORD_END: begin
                dec_op.kind = wdfa_pkg::OP_WORD;
                keep        = 1'b1;
            end
            wdfa_pkg::CMD_STREAM_END: begin
                dec_op.kind = wdfa_pkg::OP_END;
                keep        = 1'b1;
            end
            wdfa_pkg::CMD_WR_TRANS: begin
                dec_op.kind = wdfa_pkg::OP_WR_TRANS;
                keep        = sym_ok && row_ok && dim_ok;
            end
            wdfa_pkg::CMD_WR_FINAL: begin
                dec_op.kind = wdfa_pkg::OP_WR_FINAL;
                keep        = row_ok && dim_ok;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // one-entry holding register toward the queue
    always_comb begin
        s_ready      = !f_valid_reg || q_ready;
        accept       = s_valid && s_ready;
        f_valid_next = accept ? keep : (f_valid_reg && !q_ready);
        f_op_next    = accept ? dec_op : f_op_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        f_op_reg <= f_op_next;
    end

    assign q_valid = f_valid_reg;
    assign q_op    = f_op_reg;

endmodule

// ----- sv/wdfa_fifo.sv -----
`timescale 1ns / 1ps

module wdfa_fifo #(
    parameter int DEPTH = wdfa_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  wdfa_pkg::op_t in_op,
    output logic          out_valid,
    output wdfa_pkg::op_t out_op,
    input  logic          out_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wdfa_pkg::op_t  slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push, pop;

    // pointer and fill bookkeeping
    always_comb begin
        in_ready    = count_reg != CW'(DEPTH);
        out_valid   = count_reg != '0;
        push        = in_valid && in_ready;
        pop         = out_pop && out_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_op;
        end
    end

    assign out_op = slot_reg[rd_ptr_reg];

endmodule

// ----- sv/wdfa_back.sv -----
`timescale 1ns / 1ps

module wdfa_back #(
    parameter int STATES  = wdfa_pkg::STATES_DEF,
    parameter int SYMBOLS = wdfa_pkg::SYMBOLS_DEF,
    parameter int DIMS    = wdfa_pkg::DIMS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [wdfa_pkg::STATE_W-1:0]        cfg_wdata,
    input  logic                                q_valid,
    input  wdfa_pkg::op_t                       q_op,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wdfa_pkg::TOT_W-1:0]   m_total,
    output logic [wdfa_pkg::DIM_W-1:0]          m_dimension,
    output logic                                m_last
);

    localparam int TDEPTH  = SYMBOLS * STATES;
    localparam int TAW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int FAW     = (STATES > 1) ? $clog2(STATES) : 1;
    localparam int DW      = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int STATE_W = wdfa_pkg::STATE_W;
    localparam int CNT_W   = wdfa_pkg::CNT_W;
    localparam int ACC_W   = wdfa_pkg::ACC_W;
    localparam int FREQ_W  = wdfa_pkg::FREQ_W;
    localparam int TOT_W   = wdfa_pkg::TOT_W;

    typedef enum logic [1:0] {
        RK_STEP,
        RK_ZERO,
        RK_WORD,
        RK_END
    } r_kind_t;

    // control
    logic                 adv;
    logic [STATE_W-1:0]   start_reg;
    logic [STATE_W-1:0]   state_reg;
    logic [STATE_W-1:0]   state_after;
    logic                 cur_ok;
    logic [STATE_W-1:0]   row_sel;
    logic [TAW-1:0]       taddr;
    logic [FAW-1:0]       faddr;
    logic                 t_re, t_we, f_re;
    logic                 is_wr_trans, is_wr_final;

    // memory read data
    logic [STATE_W-1:0]   tgt_rdata;
    logic [CNT_W-1:0]     cnt_rdata [DIMS];
    logic [CNT_W-1:0]     fin_rdata [DIMS];

    // read stage
    logic                 r_valid_reg, r_valid_next;
    r_kind_t              r_kind_reg, r_kind_next;
    logic                 r_fin_ok_reg;
    logic signed [FREQ_W-1:0] r_freq_reg;
    logic [ACC_W-1:0]     acc_reg [DIMS];
    logic [ACC_W-1:0]     acc_step [DIMS];
    logic [ACC_W-1:0]     acc_word [DIMS];

    // multiply stage
    logic                 mul_valid_reg;
    logic                 mul_end_reg;
    logic signed [ACC_W-1:0]  mul_w_reg [DIMS];
    logic signed [FREQ_W-1:0] mul_freq_reg;
    logic signed [TOT_W-1:0]  prd_next [DIMS];

    // product stage and totals
    logic                 prd_valid_reg;
    logic                 prd_end_reg;
    logic signed [TOT_W-1:0]  prd_reg [DIMS];
    logic [TOT_W-1:0]     tot_reg [DIMS];

    // result emitter
    logic                 emit_busy_reg;
    logic [DW-1:0]        emit_cnt_reg;
    logic [TOT_W-1:0]     ebuf_reg [DIMS];
    logic                 emit_last;
    logic                 emit_free;
    logic                 emit_load;
    logic                 emit_xfer;

    // pipeline advance: only a stream end that finds the emitter busy holds it
    always_comb begin
        emit_last = emit_cnt_reg == DW'(DIMS - 1);
        emit_xfer = emit_busy_reg && m_ready;
        emit_free = !emit_busy_reg || (m_ready && emit_last);
        adv       = !(prd_valid_reg && prd_end_reg && !emit_free);
        emit_load = adv && prd_valid_reg && prd_end_reg;
        q_pop     = q_valid && adv;
    end

    // start state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
        end else if (cfg_valid) begin
            start_reg <= cfg_wdata;
        end
    end

    // state as it stands once the read stage commits
    always_comb begin
        state_after = state_reg;
        if (r_valid_reg) begin
            case (r_kind_reg)
                RK_STEP: state_after = tgt_rdata;
                RK_ZERO: state_after = '0;
                RK_WORD: state_after = start_reg;
                default: state_after = state_reg;
            endcase
        end
    end

    // issue: addresses, reads and table writes
    always_comb begin
        is_wr_trans = q_op.kind == wdfa_pkg::OP_WR_TRANS;
        is_wr_final = q_op.kind == wdfa_pkg::OP_WR_FINAL;
        cur_ok      = 32'(state_after) < 32'(STATES);
        row_sel     = (is_wr_trans || is_wr_final) ? q_op.state_index : state_after;
        taddr       = TAW'(TAW'(q_op.symbol) * TAW'(STATES) + TAW'(row_sel));
        faddr       = FAW'(row_sel);
        t_re        = q_pop && (q_op.kind == wdfa_pkg::OP_STEP) && cur_ok;
        t_we        = q_pop && is_wr_trans;
        f_re        = q_pop && (q_op.kind == wdfa_pkg::OP_WORD);
    end

    // read-stage kind
    always_comb begin
        r_valid_next = 1'b0;
        r_kind_next  = RK_END;
        if (q_pop) begin
            case (q_op.kind)
                wdfa_pkg::OP_STEP: begin
                    r_valid_next = 1'b1;
                    r_kind_next  = cur_ok ? RK_STEP : RK_ZERO;
                end
                wdfa_pkg::OP_WORD: begin
                    r_valid_next = 1'b1;
                    r_kind_next  = RK_WORD;
                end
                wdfa_pkg::OP_END: begin
                    r_valid_next = 1'b1;
                    r_kind_next  = RK_END;
                end
                default: begin
                    r_valid_next = 1'b0;
                end
            endcase
        end
    end

    // transition target table
    wdfa_ram #(
        .WIDTH (STATE_W),
        .DEPTH (TDEPTH)
    ) u_tgt_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (taddr),
        .wdata (q_op.next_state),
        .re    (t_re),
        .raddr (taddr),
        .rdata (tgt_rdata)
    );

    // count tables, one memory per dimension
    for (genvar d = 0; d < DIMS; d++) begin : g_dim_ram
        logic dim_hit;
        assign dim_hit = 32'(q_op.dim_index) == 32'(d);

        wdfa_ram #(
            .WIDTH (CNT_W),
            .DEPTH (TDEPTH)
        ) u_cnt_ram (
            .aclk  (aclk),
            .we    (t_we && dim_hit),
            .waddr (taddr),
            .wdata (q_op.count_value),
            .re    (t_re),
            .raddr (taddr),
            .rdata (cnt_rdata[d])
        );

        wdfa_ram #(
            .WIDTH (CNT_W),
            .DEPTH (STATES)
        ) u_fin_ram (
            .aclk  (aclk),
            .we    (q_pop && is_wr_final && dim_hit),
            .waddr (faddr),
            .wdata (q_op.count_value),
            .re    (f_re),
            .raddr (faddr),
            .rdata (fin_rdata[d])
        );
    end

    // read-stage sums per dimension
    always_comb begin
        for (int d = 0; d < DIMS; d++) begin
            acc_step[d] = acc_reg[d] + ACC_W'($signed(cnt_rdata[d]));
            acc_word[d] = acc_reg[d] + (r_fin_ok_reg ? ACC_W'($signed(fin_rdata[d])) : '0);
        end
    end

    // multiply per dimension, full 64-bit product
    always_comb begin
        for (int d = 0; d < DIMS; d++) begin
            prd_next[d] = mul_w_reg[d] * mul_freq_reg;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            r_valid_reg   <= 1'b0;
            r_kind_reg    <= RK_END;
            mul_valid_reg <= 1'b0;
            mul_end_reg   <= 1'b0;
            prd_valid_reg <= 1'b0;
            prd_end_reg   <= 1'b0;
            for (int d = 0; d < DIMS; d++) begin
                acc_reg[d] <= '0;
                tot_reg[d] <= '0;
            end
        end else if (adv) begin
            state_reg     <= state_after;
            r_valid_reg   <= r_valid_next;
            r_kind_reg    <= r_kind_next;
            mul_valid_reg <= r_valid_reg && (r_kind_reg == RK_WORD || r_kind_reg == RK_END);
            mul_end_reg   <= r_kind_reg == RK_END;
            prd_valid_reg <= mul_valid_reg;
            prd_end_reg   <= mul_end_reg;
            for (int d = 0; d < DIMS; d++) begin
                if (r_valid_reg && r_kind_reg == RK_STEP) begin
                    acc_reg[d] <= acc_step[d];
                end else if (r_valid_reg && r_kind_reg == RK_WORD) begin
                    acc_reg[d] <= '0;
                end
                if (prd_valid_reg && prd_end_reg) begin
                    tot_reg[d] <= '0;
                end else if (prd_valid_reg) begin
                    tot_reg[d] <= tot_reg[d] + TOT_W'(prd_reg[d]);
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            r_fin_ok_reg <= cur_ok;
            r_freq_reg   <= q_op.frequency;
            mul_freq_reg <= r_freq_reg;
            for (int d = 0; d < DIMS; d++) begin
                mul_w_reg[d] <= acc_word[d];
                prd_reg[d]   <= prd_next[d];
            end
        end
    end

    // emitter control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_busy_reg <= 1'b0;
            emit_cnt_reg  <= '0;
        end else if (emit_load) begin
            emit_busy_reg <= 1'b1;
            emit_cnt_reg  <= '0;
        end else if (emit_xfer) begin
            emit_busy_reg <= !emit_last;
            emit_cnt_reg  <= emit_last ? '0 : emit_cnt_reg + 1'b1;
        end
    end

    // emitter buffer, shifts one dimension out per transfer
    always_ff @(posedge aclk) begin
        if (emit_load) begin
            for (int d = 0; d < DIMS; d++) begin
                ebuf_reg[d] <= tot_reg[d];
            end
        end else if (emit_xfer) begin
            for (int d = 0; d < DIMS - 1; d++) begin
                ebuf_reg[d] <= ebuf_reg[d + 1];
            end
        end
    end

    assign m_valid     = emit_busy_reg;
    assign m_total     = ebuf_reg[0];
    assign m_dimension = wdfa_pkg::DIM_W'(emit_cnt_reg);
    assign m_last      = emit_last;

    // a run is not cut short before its last dimension
    a_emit_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_busy_reg && m_ready && !emit_last) |=> emit_busy_reg)
        else $error("emitter dropped out before the last dimension");

    // a word end clears the accumulator and returns to the start state
    a_word_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && r_valid_reg && r_kind_reg == RK_WORD) |=> (acc_reg[0] == '0))
        else $error("word accumulator not cleared at word end");

    a_word_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && r_valid_reg && r_kind_reg == RK_WORD) |=> (state_reg == $past(start_reg)))
        else $error("state did not return to start state at word end");

    // a stream end starts a run at dimension zero and clears the totals
    a_end_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && prd_valid_reg && prd_end_reg)
            |=> (emit_busy_reg && emit_cnt_reg == '0 && tot_reg[0] == '0))
        else $error("stream end did not load the emitter");

endmodule

// ----- sv/weighted_dfa_count_transducer.sv -----
`timescale 1ns / 1ps

// channel   | handshake               | payload
// ----------+-------------------------+------------------------------------------------
// input     | s_valid / s_ready       | s_cmd s_symbol s_state_index s_next_state
//           |                         | s_dim_index s_count_value s_frequency
// result    | m_valid / m_ready       | m_total m_dimension m_last
// config    | cfg_valid / cfg_ready   | cfg_wdata (start state)
//
// One input item is taken per cycle for symbols, word ends and table writes while the
// queue has room and no stream end holds the pipeline; the transition target memory sets
// that rate, its registered read data forming the next symbol's read address. A stream
// end makes DIMS results, one per cycle while m_ready is high, after the read, multiply
// and product stages; a second one waits at the totals stage until the previous run drains.
// Reset (aresetn low, synchronous) clears state, start state, accumulators and totals.

module weighted_dfa_count_transducer #(
    parameter int STATES  = wdfa_pkg::STATES_DEF,
    parameter int SYMBOLS = wdfa_pkg::SYMBOLS_DEF,
    parameter int DIMS    = wdfa_pkg::DIMS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wdfa_pkg::CMD_W-1:0]          s_cmd,
    input  logic [wdfa_pkg::SYM_W-1:0]          s_symbol,
    input  logic [wdfa_pkg::STATE_W-1:0]        s_state_index,
    input  logic [wdfa_pkg::STATE_W-1:0]        s_next_state,
    input  logic [wdfa_pkg::DIM_W-1:0]          s_dim_index,
    input  logic signed [wdfa_pkg::CNT_W-1:0]   s_count_value,
    input  logic signed [wdfa_pkg::FREQ_W-1:0]  s_frequency,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [wdfa_pkg::TOT_W-1:0]   m_total,
    output logic [wdfa_pkg::DIM_W-1:0]          m_dimension,
    output logic                                m_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wdfa_pkg::STATE_W-1:0]        cfg_wdata
);

    logic          fq_valid, fq_ready;
    wdfa_pkg::op_t fq_op;
    logic          bq_valid, bq_pop;
    wdfa_pkg::op_t bq_op;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // accept and classify
    wdfa_front #(
        .STATES  (STATES),
        .SYMBOLS (SYMBOLS),
        .DIMS    (DIMS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_symbol      (s_symbol),
        .s_state_index (s_state_index),
        .s_next_state  (s_next_state),
        .s_dim_index   (s_dim_index),
        .s_count_value (s_count_value),
        .s_frequency   (s_frequency),
        .q_valid       (fq_valid),
        .q_op          (fq_op),
        .q_ready       (fq_ready)
    );

    // decoupling queue
    wdfa_fifo #(
        .DEPTH (wdfa_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_op     (fq_op),
        .out_valid (bq_valid),
        .out_op    (bq_op),
        .out_pop   (bq_pop)
    );

    // execute and emit
    wdfa_back #(
        .STATES  (STATES),
        .SYMBOLS (SYMBOLS),
        .DIMS    (DIMS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_wdata   (cfg_wdata),
        .q_valid     (bq_valid),
        .q_op        (bq_op),
        .q_pop       (bq_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_total     (m_total),
        .m_dimension (m_dimension),
        .m_last      (m_last)
    );

endmodule

// ----- tb/sv/dfa_total_checker.sv -----
`timescale 1ns / 1ps

module dfa_total_checker #(
    parameter int STATES  = wdfa_pkg::STATES_DEF,
    parameter int SYMBOLS = wdfa_pkg::SYMBOLS_DEF,
    parameter int DIMS    = wdfa_pkg::DIMS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [wdfa_pkg::CMD_W-1:0]          s_cmd,
    input  logic [wdfa_pkg::SYM_W-1:0]          s_symbol,
    input  logic [wdfa_pkg::STATE_W-1:0]        s_state_index,
    input  logic [wdfa_pkg::STATE_W-1:0]        s_next_state,
    input  logic [wdfa_pkg::DIM_W-1:0]          s_dim_index,
    input  logic signed [wdfa_pkg::CNT_W-1:0]   s_count_value,
    input  logic signed [wdfa_pkg::FREQ_W-1:0]  s_frequency,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [wdfa_pkg::TOT_W-1:0]   m_total,
    input  logic [wdfa_pkg::DIM_W-1:0]          m_dimension,
    input  logic                                m_last,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [wdfa_pkg::STATE_W-1:0]        cfg_wdata,
    output int                                  mismatches,
    output int                                  pending
);

    import wdfa_pkg::*;

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic signed [TOT_W-1:0] total;
        logic [DIM_W-1:0]        dimension;
        logic                    last;
    } total_beat_t;

    // automaton tables, kept across reset like the block's memories
    bit [STATE_W-1:0] target_mem    [SYMBOLS*STATES];
    bit [CNT_W-1:0]   step_cnt_mem  [SYMBOLS*STATES*DIMS];
    bit [CNT_W-1:0]   final_cnt_mem [STATES*DIMS];

    // register and running state
    bit [STATE_W-1:0]        start_reg;
    int                      cur_state;
    bit signed [ACC_W-1:0]   word_sum  [DIMS];
    bit signed [TOT_W-1:0]   run_total [DIMS];
    total_beat_t             totals_due [$];

    task automatic report_mismatch(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("result mismatch on %s: expected %0d, got %0d", field, want, got);
    endtask

    // apply one accepted input transfer to the automaton and the totals
    task automatic step_automaton(
        input logic [CMD_W-1:0]          op,
        input logic [SYM_W-1:0]          sym,
        input logic [STATE_W-1:0]        row,
        input logic [STATE_W-1:0]        nxt,
        input logic [DIM_W-1:0]          dim,
        input logic [CNT_W-1:0]          cnt,
        input logic signed [FREQ_W-1:0]  freq
    );
        int                    slot;
        bit signed [ACC_W-1:0] w;
        total_beat_t           beat;
        case (op)
            CMD_SYMBOL: begin
                if (sym < SYMBOLS) begin
                    if (cur_state >= STATES) begin
                        cur_state = 0;
                    end else begin
                        slot = sym * STATES + cur_state;
                        cur_state = int'(target_mem[slot]);
                        for (int d = 0; d < DIMS; d++)
                            word_sum[d] = word_sum[d] + $signed(step_cnt_mem[slot*DIMS+d]);
                    end
                end
            end
            CMD_WORD_END: begin
                // exact 64-bit product of word count and frequency
                for (int d = 0; d < DIMS; d++) begin
                    w = word_sum[d];
                    if (cur_state < STATES)
                        w = w + $signed(final_cnt_mem[cur_state*DIMS+d]);
                    run_total[d] = run_total[d] + longint'(w) * longint'(freq);
                    word_sum[d] = '0;
                end
                cur_state = int'(start_reg);
            end
            CMD_STREAM_END: begin
                for (int d = 0; d < DIMS; d++) begin
                    beat.total     = run_total[d];
                    beat.dimension = DIM_W'(d);
                    beat.last      = (d == DIMS - 1);
                    totals_due.push_back(beat);
                    run_total[d] = '0;
                end
            end
            CMD_WR_TRANS: begin
                if (sym < SYMBOLS && row < STATES && dim < DIMS) begin
                    slot = sym * STATES + row;
                    target_mem[slot] = nxt;
                    step_cnt_mem[slot*DIMS+dim] = cnt;
                end
            end
            CMD_WR_FINAL: begin
                if (row < STATES && dim < DIMS)
                    final_cnt_mem[row*DIMS+dim] = cnt;
            end
            default: ;
        endcase
    endtask

    // watch all three channels on the rising edge
    always @(posedge aclk) begin : watch
        total_beat_t due;
        if (!aresetn) begin
            mismatches = 0;
            start_reg = '0;
            cur_state = 0;
            for (int d = 0; d < DIMS; d++) begin
                word_sum[d]  = '0;
                run_total[d] = '0;
            end
            totals_due.delete();
        end else begin
            // result transfer against the oldest expected total
            if (m_valid && m_ready) begin
                if (totals_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("result with none expected: total %0d dimension %0d last %0d",
                                 m_total, m_dimension, m_last);
                end else begin
                    due = totals_due.pop_front();
                    if (m_total !== due.total)
                        report_mismatch("total", due.total, m_total);
                    if (m_dimension !== due.dimension)
                        report_mismatch("dimension", due.dimension, m_dimension);
                    if (m_last !== due.last)
                        report_mismatch("last", due.last, m_last);
                end
            end
            if (cfg_valid && cfg_ready)
                start_reg = cfg_wdata;
            if (s_valid && s_ready)
                step_automaton(s_cmd, s_symbol, s_state_index, s_next_state,
                               s_dim_index, s_count_value, s_frequency);
        end
        pending = totals_due.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import wdfa_pkg::*;

    localparam int NSTATES       = STATES_DEF;
    localparam int NSYMS         = SYMBOLS_DEF;
    localparam int NDIMS         = DIMS_DEF;
    localparam int POOL          = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 200000;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam bit [NDIMS-1:0] FULL_MASK = '1;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_cmd;
    logic [SYM_W-1:0]           s_symbol;
    logic [STATE_W-1:0]         s_state_index;
    logic [STATE_W-1:0]         s_next_state;
    logic [DIM_W-1:0]           s_dim_index;
    logic signed [CNT_W-1:0]    s_count_value;
    logic signed [FREQ_W-1:0]   s_frequency;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [TOT_W-1:0]    m_total;
    logic [DIM_W-1:0]           m_dimension;
    logic                       m_last;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [STATE_W-1:0]         cfg_wdata;
    int                         mismatches;
    int                         pending;

    // which table entries are written, so no unwritten entry is ever read
    bit [STATE_W-1:0] path_tgt  [NSYMS*NSTATES];
    bit [NDIMS-1:0]   path_dims [NSYMS*NSTATES];
    bit [NDIMS-1:0]   fin_dims  [NSTATES];
    int               walk_state;
    int               walk_start;
    int               st_pool  [POOL];
    int               sym_pool [POOL];

    int send_pct;
    int recv_pct;
    bit hold_req;
    bit hold_done;

    weighted_dfa_count_transducer dut (.*);

    dfa_total_checker checker_i (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        m_ready   = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready = ($urandom_range(99) >= recv_pct);
            end
        end
    end

    function automatic logic [CNT_W-1:0] extreme_count(input int k);
        case (k % 4)
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] any_count();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            default: return CNT_W'($urandom);
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] any_freq();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return $urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    // a symbol whose entry is fully written and leads to a state with final counts
    function automatic int legal_symbol();
        int choices[$];
        int slot;
        int s;
        for (s = 0; s < NSYMS; s++) begin
            slot = s * NSTATES + walk_state;
            if (path_dims[slot] == FULL_MASK && fin_dims[path_tgt[slot]] == FULL_MASK)
                choices.push_back(s);
        end
        if (choices.size() == 0)
            return -1;
        return choices[$urandom_range(choices.size() - 1)];
    endfunction

    // drive one input transfer and track what it writes or moves
    task automatic issue(
        input logic [CMD_W-1:0]   op,
        input logic [SYM_W-1:0]   sym,
        input logic [STATE_W-1:0] row,
        input logic [STATE_W-1:0] nxt,
        input logic [DIM_W-1:0]   dim,
        input logic [CNT_W-1:0]   cnt,
        input logic [FREQ_W-1:0]  freq
    );
        int slot;
        case (op)
            CMD_SYMBOL: begin
                slot = sym * NSTATES + walk_state;
                walk_state = int'(path_tgt[slot]);
            end
            CMD_WORD_END: walk_state = walk_start;
            CMD_WR_TRANS: begin
                slot = sym * NSTATES + row;
                path_tgt[slot] = nxt;
                path_dims[slot][dim] = 1'b1;
            end
            CMD_WR_FINAL: fin_dims[row][dim] = 1'b1;
            default: ;
        endcase
        @(negedge aclk);
        while ($urandom_range(99) < send_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_cmd         = op;
        s_symbol      = sym;
        s_state_index = row;
        s_next_state  = nxt;
        s_dim_index   = dim;
        s_count_value = cnt;
        s_frequency   = freq;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic step_symbol(input int sym);
        issue(CMD_SYMBOL, SYM_W'(sym), STATE_W'($urandom), STATE_W'($urandom),
              DIM_W'($urandom), CNT_W'($urandom), $urandom);
    endtask

    task automatic end_word(input logic [FREQ_W-1:0] freq);
        issue(CMD_WORD_END, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom),
              DIM_W'($urandom), CNT_W'($urandom), freq);
    endtask

    task automatic end_stream();
        issue(CMD_STREAM_END, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom),
              DIM_W'($urandom), CNT_W'($urandom), $urandom);
    endtask

    // full transition entry: target plus every dimension's count
    task automatic write_row(input int sym, input int row, input int nxt, input bit extremes);
        for (int d = 0; d < NDIMS; d++)
            issue(CMD_WR_TRANS, SYM_W'(sym), STATE_W'(row), STATE_W'(nxt), DIM_W'(d),
                  extremes ? extreme_count(d) : any_count(), $urandom);
    endtask

    task automatic write_final(input int row, input bit extremes);
        for (int d = 0; d < NDIMS; d++)
            issue(CMD_WR_FINAL, SYM_W'($urandom), STATE_W'(row), STATE_W'($urandom), DIM_W'(d),
                  extremes ? extreme_count(d) : any_count(), $urandom);
    endtask

    task automatic walk_or_end();
        int sym;
        sym = legal_symbol();
        if (sym >= 0)
            step_symbol(sym);
        else
            end_word(any_freq());
    endtask

    // stop offering and wait for the block to go quiet
    task automatic drain_block();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_start(input int st);
        drain_block();
        cfg_valid = 1'b1;
        cfg_wdata = STATE_W'(st);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        walk_start = st;
    endtask

    // random words over the pooled rows, with table writes and noise mixed in
    task automatic run_mix(input int count);
        int n;
        int r;
        n = 0;
        while (n < count) begin
            r = $urandom_range(99);
            if (r < 50) begin
                walk_or_end();
                n++;
            end else if (r < 66) begin
                if (fin_dims[walk_state] == FULL_MASK)
                    end_word(any_freq());
                else
                    end_stream();
                n++;
            end else if (r < 72) begin
                end_stream();
                n++;
            end else if (r < 82) begin
                write_row(sym_pool[$urandom_range(POOL-1)], st_pool[$urandom_range(POOL-1)],
                          st_pool[$urandom_range(POOL-1)], 1'b0);
                n += NDIMS;
            end else if (r < 86) begin
                write_final(st_pool[$urandom_range(POOL-1)], 1'b0);
                n += NDIMS;
            end else if (r < 93) begin
                issue($urandom_range(1) ? CMD_WR_TRANS : CMD_WR_FINAL, SYM_W'($urandom),
                      STATE_W'($urandom), STATE_W'($urandom), DIM_W'($urandom),
                      CNT_W'($urandom), $urandom);
                n++;
            end else begin
                issue(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), SYM_W'($urandom),
                      STATE_W'($urandom), STATE_W'($urandom), DIM_W'($urandom),
                      CNT_W'($urandom), $urandom);
                n++;
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_cmd         = CMD_SYMBOL;
        s_symbol      = '0;
        s_state_index = '0;
        s_next_state  = '0;
        s_dim_index   = '0;
        s_count_value = '0;
        s_frequency   = '0;
        cfg_valid     = 1'b0;
        cfg_wdata     = '0;
        send_pct      = 0;
        recv_pct      = 0;
        hold_req      = 1'b0;
        walk_state    = 0;
        walk_start    = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        set_start(0);

        // directed: extreme counts and frequencies, edge states and symbols
        write_final(0, 1'b1);
        write_final(NSTATES - 1, 1'b0);
        write_row(NSYMS - 1, 0, NSTATES - 1, 1'b1);
        write_row(0, NSTATES - 1, 0, 1'b1);
        step_symbol(NSYMS - 1);
        step_symbol(0);
        step_symbol(NSYMS - 1);
        // stream end mid word leaves state and word sums alone
        end_stream();
        end_word(32'h8000_0000);
        // empty word: only the start state's final counts
        end_word(32'h7FFF_FFFF);
        end_word(32'hFFFF_FFFF);
        issue(CMD_SPARE_LO, SYM_W'($urandom), STATE_W'($urandom), STATE_W'($urandom),
              DIM_W'($urandom), CNT_W'($urandom), $urandom);
        // back-to-back stream ends, the second one waits for the first run
        end_stream();
        end_stream();

        // pooled states and symbols that the random words run over
        st_pool[0]  = 0;
        st_pool[1]  = NSTATES - 1;
        sym_pool[0] = 0;
        sym_pool[1] = NSYMS - 1;
        for (int i = 2; i < POOL; i++) begin
            st_pool[i]  = $urandom_range(NSTATES - 1);
            sym_pool[i] = $urandom_range(NSYMS - 1);
        end
        for (int i = 0; i < POOL; i++)
            write_final(st_pool[i], 1'b0);
        for (int i = 0; i < POOL; i++) begin
            write_row(sym_pool[$urandom_range(POOL-1)], st_pool[i],
                      st_pool[$urandom_range(POOL-1)], 1'b0);
            write_row(sym_pool[$urandom_range(POOL-1)], st_pool[i],
                      st_pool[$urandom_range(POOL-1)], 1'b0);
        end

        // long result hold-off while stream ends keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++) begin
            if (i % 6 == 5)
                end_stream();
            else
                walk_or_end();
        end
        run_mix(40);

        set_start(NSTATES - 1);
        send_pct = 64;
        recv_pct = 0;
        run_mix(90);

        set_start(st_pool[$urandom_range(POOL-1)]);
        send_pct = 0;
        recv_pct = 64;
        run_mix(90);

        set_start(0);
        send_pct = 13;
        recv_pct = 13;
        run_mix(90);
        end_stream();

        drain_block();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- weighted_dfa_count_transducer.f -----
sv/wdfa_pkg.sv
sv/wdfa_ram.sv
sv/wdfa_front.sv
sv/wdfa_fifo.sv
sv/wdfa_back.sv
sv/weighted_dfa_count_transducer.sv
tb/sv/dfa_total_checker.sv
tb/sv/testbench.sv
